@@ hdl/moving_average_filter_top_defines.svh @@
// assertion macros for the moving average filter
`ifndef MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MAF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

@@ hdl/mavg_pkg.sv @@
package mavg_pkg;

    localparam int CFG_W        = 6;
    localparam int WINDOW_RESET = 16;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

@@ hdl/moving_average_filter_top.sv @@
// channel   direction  handshake                          payload
// sample    in         i_sample_valid / o_sample_ready    i_sample
// average   out        o_average_valid / i_average_ready  o_average
// config    in         i_cfg_wr_en                        i_cfg_wr_data
//
// one request runs through read, update, divide and done before the next sample is accepted,
// the divide done by the one-bit-per-cycle restoring divider
// a result register holds the average so the next sample is taken while it waits
// a stalled result holds the divider done until the register frees up
// synchronous active-low reset; the sample store needs no clearing, the fill count guards it
module moving_average_filter_top
    import mavg_pkg::*;
#(
    parameter int STORE_DEPTH = 32,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_average_valid,
    input  logic                   i_average_ready,
    output logic [SAMPLE_BITS-1:0] o_average
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(STORE_DEPTH);

    t_cmd    cmd;
    t_status status;

    mavg_ctrl #(
        .STEPS (SUM_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    mavg_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_sample        (i_sample),
        .i_average_ready (i_average_ready),
        .o_average_valid (o_average_valid),
        .o_average       (o_average),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule

@@ hdl/mavg_ram.sv @@
module mavg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/mavg_ctrl.sv @@
module mavg_ctrl
    import mavg_pkg::*;
#(
    parameter int STEPS = 17
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int STEP_W = $clog2(STEPS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DIVIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_step    = '0;
                n_state   = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_sample_ready = (r_state == S_IDLE);

endmodule

@@ hdl/mavg_datapath.sv @@
`include "moving_average_filter_top_defines.svh"

module mavg_datapath
    import mavg_pkg::*;
#(
    parameter int STORE_DEPTH = 32,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_average_ready,
    output logic                   o_average_valid,
    output logic [SAMPLE_BITS-1:0] o_average,
    input  t_cmd                   i_cmd,
    output t_status                o_status
);

    localparam int POS_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + POS_W;
    localparam int WIN_INIT = (WINDOW_RESET > STORE_DEPTH) ? STORE_DEPTH : WINDOW_RESET;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [POS_W-1:0]       r_pos;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       r_window;
    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_average;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   full;
    logic [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]       n_fill;
    logic [POS_W-1:0]       pos_eff;
    logic [CNT_W-1:0]       pos_inc;
    logic [POS_W-1:0]       n_pos;
    logic [CNT_W-1:0]       cfg_window;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W:0]         rem_diff;
    logic                   rem_ge;

    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.upd),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_window = CNT_W'(1);
        end else if (int'(i_cfg_wr_data) > STORE_DEPTH) begin
            cfg_window = CNT_W'(STORE_DEPTH);
        end else begin
            cfg_window = CNT_W'(i_cfg_wr_data);
        end
    end

    assign pos_eff = (CNT_W'(r_pos) >= r_window) ? '0 : r_pos;
    assign full    = (r_fill >= r_window);
    assign n_sum   = r_sum - (full ? SUM_W'(rd_data) : '0) + SUM_W'(r_sample);
    assign n_fill  = full ? r_fill : r_fill + CNT_W'(1);
    assign pos_inc = CNT_W'(r_pos) + CNT_W'(1);
    assign n_pos   = (pos_inc >= r_window) ? '0 : pos_inc[POS_W-1:0];

    // restoring divide, one quotient bit per step
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_fill});
    assign rem_diff = rem_sh - {1'b0, r_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_window    <= CNT_W'(WIN_INIT);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= cfg_window;
                r_pos    <= '0;
                r_sum    <= '0;
                r_fill   <= '0;
            end else if (i_cmd.load) begin
                r_pos <= pos_eff;
            end else if (i_cmd.upd) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_pos  <= n_pos;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_average_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.upd) begin
            r_quo <= n_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_average <= r_quo[SAMPLE_BITS-1:0];
        end
    end

    assign o_status.out_free = !r_out_valid || i_average_ready;
    assign o_average_valid   = r_out_valid;
    assign o_average         = r_average;

    `MAF_ASSERT(a_fill_in_window, i_clk, i_rst_n, r_fill <= r_window, "fill count above window")
    `MAF_ASSERT(a_pos_in_window, i_clk, i_rst_n, CNT_W'(r_pos) < r_window, "write position outside window")
    `MAF_ASSERT(a_window_nonzero, i_clk, i_rst_n, r_window != '0, "window length of zero")
    `MAF_ASSERT_NEXT(a_fill_after_upd, i_clk, i_rst_n, i_cmd.upd && !i_cfg_wr_en, r_fill != '0, "zero divisor after update")
    `MAF_ASSERT(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load |-> (!r_out_valid || i_average_ready), "result overwritten")

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int DEPTH      = 32;
    localparam int SBITS      = 12;
    localparam int MAX_CYCLES = 500000;
    localparam int HOLD_LEN   = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             i_sample_valid = 1'b0;
    logic             o_sample_ready;
    logic [SBITS-1:0] i_sample = '0;
    logic             o_average_valid;
    logic             i_average_ready = 1'b0;
    logic [SBITS-1:0] o_average;

    // filter state mirrored from the block
    logic [SBITS-1:0] hist [DEPTH];
    logic [4:0]       wr_pos;
    logic [16:0]      sum_acc;
    logic [5:0]       fill_cnt;
    logic [5:0]       win_len;

    logic [SBITS-1:0] avg_expected [$];
    logic [SBITS-1:0] avg_want;

    int  fails = 0;
    int  samples_sent = 0;
    int  averages_checked = 0;
    int  window_writes = 0;
    int  cycle_cnt = 0;
    int  hold_off_cycles = 0;
    bit  gaps_on = 1'b0;

    moving_average_filter_top #(
        .STORE_DEPTH(DEPTH),
        .SAMPLE_BITS(SBITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_average_valid(o_average_valid),
        .i_average_ready(i_average_ready),
        .o_average      (o_average)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("%0t timeout with %0d averages outstanding", $time, avg_expected.size());
            $display("moving_average_filter_top verification failed");
            $finish;
        end
    end

    function automatic void clear_window_state();
        foreach (hist[k]) hist[k] = '0;
        wr_pos   = '0;
        sum_acc  = '0;
        fill_cnt = '0;
    endfunction

    function automatic logic [5:0] clamp_window(input logic [CFG_W-1:0] w);
        if (w == 0) return 6'd1;
        if (w > DEPTH) return 6'(DEPTH);
        return 6'(w);
    endfunction

    function automatic logic [SBITS-1:0] next_average(input logic [SBITS-1:0] s);
        int unsigned p;
        logic [16:0] quot;
        p = wr_pos;
        if (p >= DEPTH || p >= win_len) p = 0;
        if (fill_cnt >= win_len) sum_acc = sum_acc - 17'(hist[p]);
        else fill_cnt = fill_cnt + 6'd1;
        hist[p] = s;
        sum_acc = sum_acc + 17'(s);
        p++;
        if (p >= win_len) p = 0;
        wr_pos = 5'(p);
        quot = sum_acc / 17'(fill_cnt);
        return quot[SBITS-1:0];
    endfunction

    function automatic logic [SBITS-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SBITS'($urandom_range(3900, 4095));
            3: return SBITS'($urandom_range(0, 200));
            default: return SBITS'($urandom_range(0, 4095));
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_average_valid && i_average_ready) begin
            averages_checked++;
            if (avg_expected.size() == 0) begin
                fails++;
                $display("%0t unexpected average: expected none actual %0d", $time, o_average);
            end else begin
                avg_want = avg_expected.pop_front();
                if (o_average !== avg_want) begin
                    fails++;
                    $display("%0t average mismatch: expected %0d actual %0d",
                             $time, avg_want, o_average);
                end
            end
        end
    end

    // result receiver with random stalls and the long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_average_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                i_average_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_average_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_average_ready <= 1'b1;
            end else begin
                i_average_ready <= 1'b1;
            end
        end
    end

    // leaves valid high after the accept so back-to-back requests need no second assignment
    task automatic send_sample(input logic [SBITS-1:0] s);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            i_sample_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        avg_expected.push_back(next_average(s));
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_sample_valid <= 1'b0;
        while (avg_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        win_len = clamp_window(w);
        clear_window_state();
        window_writes++;
    endtask

    task automatic test_reset_window();
        logic [SBITS-1:0] pattern [10] = '{12'h000, 12'hfff, 12'haaa, 12'h555, 12'hfff,
                                          12'hfff, 12'h001, 12'h800, 12'h7ff, 12'hfff};
        foreach (pattern[k]) send_sample(pattern[k]);
    endtask

    task automatic test_window_limits();
        // zero is taken as one
        write_window('0);
        send_sample(12'hfff);
        send_sample(12'h123);
        send_sample(12'h000);
        // above the store depth saturates
        write_window(6'd33);
        send_sample(12'hfff);
        send_sample(12'h001);
        write_window('1);
        send_sample(12'hfff);
        send_sample(12'hffe);
        // short window wraps quickly
        write_window(6'd2);
        repeat (5) send_sample(12'hfff);
        send_sample(12'h000);
    endtask

    task automatic test_random_windows();
        logic [CFG_W-1:0] picks [8] = '{6'd0, 6'd1, 6'd2, 6'd16, 6'd31, 6'd32, 6'd33, 6'd63};
        int n;
        gaps_on = 1'b1;
        while (samples_sent < 1250) begin
            if ($urandom_range(0, 1) == 0) write_window(picks[$urandom_range(0, 7)]);
            else write_window(CFG_W'($urandom_range(0, 63)));
            n = (win_len > 8) ? $urandom_range(win_len + 2, 3 * win_len) : $urandom_range(4, 40);
            repeat (n) send_sample(draw_sample());
        end
    endtask

    task automatic test_output_backpressure();
        write_window(6'd5);
        hold_off_cycles = HOLD_LEN;
        repeat (12) send_sample(draw_sample());
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        write_window(6'd32);
        repeat (70) send_sample(SBITS'($urandom_range(4000, 4095)));
        write_window(CFG_W'($urandom_range(1, 32)));
        repeat (150) send_sample(draw_sample());
    endtask

    initial begin
        win_len = 6'(WINDOW_RESET);
        clear_window_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_window_limits();
        test_random_windows();
        test_output_backpressure();
        test_steady_stream();

        wait_idle();
        repeat (30) @(posedge i_clk);
        $display("sent %0d samples across %0d window writes, checked %0d averages",
                 samples_sent, window_writes, averages_checked);
        $display("windows covered zero, one, full depth and above depth, with output hold-off");
        if (fails == 0) begin
            $display("moving_average_filter_top verification clean");
        end else begin
            $display("moving_average_filter_top verification failed");
        end
        $finish;
    end

endmodule
